@@ design/rpg_pkg.sv @@
// shared types, register codes and helper functions for the pixel glitch stream
`default_nettype none

package rpg_pkg;

	// configuration register indexes
	localparam int unsigned CfgIndexWidth = 3;
	localparam logic [CfgIndexWidth-1:0] REG_ENABLE      = 3'd0;
	localparam logic [CfgIndexWidth-1:0] REG_MODE        = 3'd1;
	localparam logic [CfgIndexWidth-1:0] REG_THRESHOLD   = 3'd2;
	localparam logic [CfgIndexWidth-1:0] REG_SEED        = 3'd3;
	localparam logic [CfgIndexWidth-1:0] REG_BEAT_SOURCE = 3'd4;

	// glitch mode codes
	localparam logic [1:0] MODE_FLIP  = 2'd0;
	localparam logic [1:0] MODE_NOISE = 2'd1;
	localparam logic [1:0] MODE_BEAT  = 2'd2;

	// reset values
	localparam logic [31:0] SEED_DEFAULT      = 32'd12345;
	localparam logic [31:0] THRESHOLD_DEFAULT = 32'h8000_0000;

	// live configuration seen by the glitch engine
	typedef struct packed {
		logic        enable;
		logic [1:0]  mode;
		logic [31:0] threshold;
		logic        beat_source;
	} cfg_t;

	// one xorshift step, shifts 13, 17, 5
	function automatic logic [31:0] xorshift32(input logic [31:0] x);
		logic [31:0] t;
		begin
			t = x ^ (x << 13);
			t = t ^ (t >> 17);
			t = t ^ (t << 5);
			return t;
		end
	endfunction

	// true when value mod 120 is zero: low three bits clear and value mod 15 zero
	function automatic logic is_mod120_zero(input logic [31:0] v);
		logic [6:0] nib_sum;
		logic [4:0] fold;
		begin
			nib_sum = '0;
			for (int i = 0; i < 8; i++) begin
				nib_sum = nib_sum + {3'b000, v[4*i +: 4]};
			end
			fold = {2'b00, nib_sum[6:4]} + {1'b0, nib_sum[3:0]};
			return (v[2:0] == 3'b000) && ((fold == 5'd0) || (fold == 5'd15));
		end
	endfunction

	// add a signed offset to a channel and clamp to 0..255
	function automatic logic [7:0] clamp_add(input logic [7:0] ch, input logic [7:0] off);
		logic signed [9:0] sum;
		begin
			sum = $signed({2'b00, ch}) + $signed({{2{off[7]}}, off});
			if (sum[9]) begin
				return 8'd0;
			end else if (sum[8]) begin
				return 8'd255;
			end else begin
				return sum[7:0];
			end
		end
	endfunction

endpackage

`default_nettype wire

@@ design/rpg_cfg_regs.sv @@
// configuration register bank with seed load strobe
`default_nettype none

module rpg_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [rpg_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  wire logic [31:0]                        cfg_data,
	output rpg_pkg::cfg_t                           cfg,
	output logic                                    seed_load
);
	import rpg_pkg::*;

	logic        enable_q;
	logic [1:0]  mode_q;
	logic [31:0] threshold_q;
	logic        beat_source_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b1;
			mode_q        <= MODE_FLIP;
			threshold_q   <= THRESHOLD_DEFAULT;
			beat_source_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ENABLE:      enable_q      <= cfg_data[0];
				REG_MODE:        mode_q        <= cfg_data[1:0];
				REG_THRESHOLD:   threshold_q   <= cfg_data;
				REG_BEAT_SOURCE: beat_source_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// seed write goes straight into the generator state
	assign seed_load = cfg_write && (cfg_index == REG_SEED);

	assign cfg.enable      = enable_q;
	assign cfg.mode        = mode_q;
	assign cfg.threshold   = threshold_q;
	assign cfg.beat_source = beat_source_q;

endmodule

`default_nettype wire

@@ design/rpg_engine.sv @@
// glitch engine: generator state, beat decision and per-pixel glitch logic
`default_nettype none

module rpg_engine (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rpg_pkg::cfg_t cfg,
	input  wire logic          seed_load,
	input  wire logic [31:0]   seed,
	input  wire logic          fire,
	input  wire logic [7:0]    red,
	input  wire logic [7:0]    green,
	input  wire logic [7:0]    blue,
	input  wire logic          frame_start,
	input  wire logic [31:0]   frame_number,
	input  wire logic          on_beat,
	output logic [7:0]         red_glitch,
	output logic [7:0]         green_glitch,
	output logic [7:0]         blue_glitch
);
	import rpg_pkg::*;

	logic [31:0] prng_q;
	logic        beat_held_q;
	logic        frame_glitch_q;

	logic        active;
	logic [31:0] word1;
	logic [31:0] word2;
	logic        hit1;
	logic        beat_eval;
	logic        frame_glitch_d;
	logic        beat_held_d;
	logic        flip;
	logic        noise;
	logic [31:0] prng_d;
	logic [7:0]  offset;

	// two chained generator steps and the first-word trigger
	assign active = cfg.enable && (cfg.threshold != 32'd0);
	assign word1  = xorshift32(prng_q);
	assign word2  = xorshift32(word1);
	assign hit1   = word1 < cfg.threshold;
	assign beat_eval = active && (cfg.mode == MODE_BEAT) && frame_start;

	// frame decision at frame start in beat mode
	always_comb begin
		frame_glitch_d = frame_glitch_q;
		beat_held_d    = beat_held_q;
		if (beat_eval) begin
			if (cfg.beat_source) begin
				frame_glitch_d = on_beat && !beat_held_q;
				beat_held_d    = on_beat;
			end else begin
				frame_glitch_d = is_mod120_zero(frame_number);
			end
		end
	end

	// glitch selection and next generator word
	always_comb begin
		flip   = 1'b0;
		noise  = 1'b0;
		prng_d = prng_q;
		if (active) begin
			unique case (cfg.mode)
				MODE_FLIP: begin
					flip   = hit1;
					prng_d = word1;
				end
				MODE_NOISE: begin
					noise  = hit1;
					prng_d = hit1 ? word2 : word1;
				end
				MODE_BEAT: begin
					flip   = frame_glitch_d && hit1;
					prng_d = frame_glitch_d ? word1 : prng_q;
				end
				default: ;
			endcase
		end
	end

	// low byte minus 128 is the low byte with its top bit inverted
	assign offset = {~word2[7], word2[6:0]};

	// pixel result
	always_comb begin
		red_glitch   = red;
		green_glitch = green;
		blue_glitch  = blue;
		if (flip) begin
			red_glitch   = ~red;
			green_glitch = ~green;
			blue_glitch  = ~blue;
		end else if (noise) begin
			red_glitch   = clamp_add(red, offset);
			green_glitch = clamp_add(green, offset);
			blue_glitch  = clamp_add(blue, offset);
		end
	end

	// state update once per pixel leaving the input stage; seed load wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prng_q         <= SEED_DEFAULT;
			beat_held_q    <= 1'b0;
			frame_glitch_q <= 1'b0;
		end else if (seed_load) begin
			prng_q <= seed;
		end else if (fire) begin
			prng_q         <= prng_d;
			beat_held_q    <= beat_held_d;
			frame_glitch_q <= frame_glitch_d;
		end
	end

endmodule

`default_nettype wire

@@ design/random_pixel_glitch_stream_core.sv @@
// top level: input stage, glitch engine and result register
// path: input stage, combinational engine, then the result register that drives out_valid
// throughput: one pixel per unstalled clock, up to two generator steps in that cycle
// a stalled output holds one result while the input stage holds one more pixel
// reset: registers take their listed reset values, generator state loads 12345,
// beat state clears, both pipeline stages empty
`default_nettype none

module random_pixel_glitch_stream_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [rpg_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  wire logic [31:0]                        cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [7:0]                         red_in,
	input  wire logic [7:0]                         green_in,
	input  wire logic [7:0]                         blue_in,
	input  wire logic                               frame_start,
	input  wire logic [31:0]                        frame_number,
	input  wire logic                               on_beat,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [7:0]                              red_out,
	output logic [7:0]                              green_out,
	output logic [7:0]                              blue_out
);
	import rpg_pkg::*;

	cfg_t        cfg;
	logic        seed_load;

	logic        valid_s1;
	logic [7:0]  red_s1;
	logic [7:0]  green_s1;
	logic [7:0]  blue_s1;
	logic        frame_start_s1;
	logic [31:0] frame_number_s1;
	logic        on_beat_s1;

	logic        out_valid_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;

	logic        stall;
	logic        fire;
	logic [7:0]  red_glitch;
	logic [7:0]  green_glitch;
	logic [7:0]  blue_glitch;

	rpg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.seed_load (seed_load)
	);

	// pipeline flow control
	assign stall    = out_valid_q && !out_ready;
	assign fire     = valid_s1 && !stall;
	assign in_ready = !valid_s1 || !stall;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			red_s1          <= red_in;
			green_s1        <= green_in;
			blue_s1         <= blue_in;
			frame_start_s1  <= frame_start;
			frame_number_s1 <= frame_number;
			on_beat_s1      <= on_beat;
		end
	end

	rpg_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.seed_load    (seed_load),
		.seed         (cfg_data),
		.fire         (fire),
		.red          (red_s1),
		.green        (green_s1),
		.blue         (blue_s1),
		.frame_start  (frame_start_s1),
		.frame_number (frame_number_s1),
		.on_beat      (on_beat_s1),
		.red_glitch   (red_glitch),
		.green_glitch (green_glitch),
		.blue_glitch  (blue_glitch)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			red_q   <= red_glitch;
			green_q <= green_glitch;
			blue_q  <= blue_glitch;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;

	// input side only backs up when both stages are full and the output stalls
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q))
		else $error("in_ready low with a free stage");

	// a pixel leaving the input stage appears as a result next cycle
	a_fire_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("fired pixel did not reach the result register");

	// an accepted beat lands in the input stage
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted beat lost before the input stage");

	// a stalled result stays valid and never moves
	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> (out_valid_q && $stable(red_q) && $stable(green_q) && $stable(blue_q)))
		else $error("result changed while stalled");

endmodule

`default_nettype wire
